### design/mpt_pkg.sv
package mpt_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int COEF_WIDTH_DEF  = 16;
    localparam int COORD_FRAC      = 16;
    localparam int COEF_FRAC       = 12;
    localparam int COEF_STRIDE     = 16;
    localparam int ROW_W           = 64;
    localparam int NUM_ROWS        = 4;
    localparam int ROW_IDX_W       = 2;
    localparam int OP_W            = 3;
    localparam int CFG_IDX_W       = 8;
    localparam int ONE_COEF        = 1 << COEF_FRAC;

    typedef enum logic [OP_W-1:0] {
        OP_POSITION   = 3'd0,
        OP_DIRECTION  = 3'd1,
        OP_TRANSPOSED = 3'd2,
        OP_INV_RIGID  = 3'd3,
        OP_PROJECTIVE = 3'd4
    } op_t;

    // Control that travels beside each stage's data
    typedef struct packed {
        logic valid;
        op_t  op;
    } ctl_t;

    // Width of one operand after the inverse-rigid subtraction
    function automatic int vec_width(input int cw, input int fw);
        return ((cw > fw + 4) ? cw : fw + 4) + 1;
    endfunction

    // Accumulator width: product plus headroom for three terms and translation
    function automatic int acc_width(input int cw, input int fw);
        return vec_width(cw, fw) + fw + 2;
    endfunction

    // Remainder width of the projective divider
    function automatic int div_width(input int cw, input int fw);
        return acc_width(cw, fw) + cw + 1;
    endfunction

    // Identity row r
    function automatic logic [ROW_W-1:0] row_reset(input int r);
        return ROW_W'(ONE_COEF) << (COEF_STRIDE * r);
    endfunction

endpackage

### design/mpt_mac.sv
module mpt_mac
    import mpt_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int COEF_WIDTH  = COEF_WIDTH_DEF
)
(
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic                                            adv,
    input  ctl_t                                            in_ctl,
    input  logic signed [COORD_WIDTH-1:0]                   in_p [0:2],
    input  logic [ROW_W-1:0]                                rows [0:NUM_ROWS-1],
    output ctl_t                                            out_ctl,
    output logic signed [acc_width(COORD_WIDTH, COEF_WIDTH)-1:0] out_acc [0:2],
    output logic signed [acc_width(COORD_WIDTH, COEF_WIDTH)-1:0] out_w
);

    localparam int TW = vec_width(COORD_WIDTH, COEF_WIDTH);
    localparam int PW = TW + COEF_WIDTH;
    localparam int AW = acc_width(COORD_WIDTH, COEF_WIDTH);
    localparam int TSH = COORD_FRAC - COEF_FRAC;

    logic [ROW_W+COEF_WIDTH-1:0]   row_ext [0:NUM_ROWS-1];
    logic signed [COEF_WIDTH-1:0]  m [0:3][0:3];

    logic signed [COEF_WIDTH-1:0]  csel_next [0:2][0:2];
    logic signed [COEF_WIDTH-1:0]  csel_reg  [0:2][0:2];
    logic signed [TW-1:0]          vsel_next [0:2];
    logic signed [TW-1:0]          vsel_reg  [0:2];
    logic signed [TW-1:0]          tvec      [0:2];
    logic signed [COEF_WIDTH-1:0]  trans_next [0:2];
    logic signed [COEF_WIDTH-1:0]  trans_reg  [0:2];
    logic signed [COORD_WIDTH-1:0] p1_reg [0:2];
    ctl_t                          ctl1_reg;

    logic signed [PW-1:0]          prod_reg  [0:2][0:2];
    logic signed [PW-1:0]          wprod_reg [0:2];
    logic signed [COEF_WIDTH-1:0]  trans2_reg [0:2];
    ctl_t                          ctl2_reg;

    logic signed [AW-1:0]          acc_reg [0:2];
    logic signed [AW-1:0]          w_reg;
    ctl_t                          ctl3_reg;

    // Unpack the coefficient matrix
    always_comb
    begin
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            row_ext[r] = {{COEF_WIDTH{1'b0}}, rows[r]};
            for (int c = 0; c < 4; c++)
            begin
                m[r][c] = row_ext[r][COEF_STRIDE*c +: COEF_WIDTH];
            end
        end
    end

    // Select coefficients and operands per mode
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            tvec[c] = TW'(in_p[c]) - (TW'(m[c][3]) <<< TSH);
        end
        for (int r = 0; r < 3; r++)
        begin
            trans_next[r] = '0;
            vsel_next[r]  = TW'(in_p[r]);
            for (int c = 0; c < 3; c++)
            begin
                csel_next[r][c] = m[r][c];
            end
        end
        case (in_ctl.op)
            OP_POSITION, OP_PROJECTIVE:
            begin
                for (int r = 0; r < 3; r++)
                begin
                    trans_next[r] = m[r][3];
                end
            end
            OP_DIRECTION:
            begin
                trans_next[0] = '0;
            end
            OP_TRANSPOSED:
            begin
                for (int r = 0; r < 3; r++)
                begin
                    for (int c = 0; c < 3; c++)
                    begin
                        csel_next[r][c] = m[c][r];
                    end
                end
            end
            OP_INV_RIGID:
            begin
                for (int r = 0; r < 3; r++)
                begin
                    vsel_next[r] = tvec[r];
                    for (int c = 0; c < 3; c++)
                    begin
                        csel_next[r][c] = m[c][r];
                    end
                end
            end
            default:
            begin
                trans_next[0] = '0;
            end
        endcase
    end

    // Control through the three stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
        end
        else if (adv)
        begin
            ctl1_reg <= in_ctl;
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl2_reg;
        end
    end

    // Stage one: operands, stage two: products, stage three: sums
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int r = 0; r < 3; r++)
            begin
                vsel_reg[r]   <= vsel_next[r];
                trans_reg[r]  <= trans_next[r];
                p1_reg[r]     <= in_p[r];
                trans2_reg[r] <= trans_reg[r];
                wprod_reg[r]  <= m[3][r] * p1_reg[r];
                acc_reg[r]    <= AW'(prod_reg[r][0]) + AW'(prod_reg[r][1])
                               + AW'(prod_reg[r][2]) + (AW'(trans2_reg[r]) <<< COORD_FRAC);
                for (int c = 0; c < 3; c++)
                begin
                    csel_reg[r][c] <= csel_next[r][c];
                    prod_reg[r][c] <= csel_reg[r][c] * vsel_reg[c];
                end
            end
            w_reg <= AW'(wprod_reg[0]) + AW'(wprod_reg[1]) + AW'(wprod_reg[2])
                   + (AW'(m[3][3]) <<< COORD_FRAC);
        end
    end

    assign out_ctl = ctl3_reg;
    assign out_acc = acc_reg;
    assign out_w   = w_reg;

endmodule

### design/mpt_div.sv
module mpt_div
    import mpt_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int COEF_WIDTH  = COEF_WIDTH_DEF,
    parameter int SIDE_W      = 3 * COORD_WIDTH_DEF + 9
)
(
    input  logic                                               clk,
    input  logic                                               rst_n,
    input  logic                                               adv,
    input  ctl_t                                               in_ctl,
    input  logic [div_width(COORD_WIDTH, COEF_WIDTH)-1:0]      in_num [0:2],
    input  logic [acc_width(COORD_WIDTH, COEF_WIDTH)-1:0]      in_den,
    input  logic [SIDE_W-1:0]                                  in_side,
    output ctl_t                                               out_ctl,
    output logic [COORD_WIDTH-1:0]                             out_q [0:2],
    output logic [SIDE_W-1:0]                                  out_side
);

    localparam int AW = acc_width(COORD_WIDTH, COEF_WIDTH);
    localparam int DW = div_width(COORD_WIDTH, COEF_WIDTH);
    localparam int NS = COORD_WIDTH;

    logic [DW-1:0]          rem_reg  [0:NS-1][0:2];
    logic [COORD_WIDTH-1:0] q_reg    [0:NS-1][0:2];
    logic [AW-1:0]          den_reg  [0:NS-1];
    logic [SIDE_W-1:0]      side_reg [0:NS-1];
    ctl_t                   ctl_reg  [0:NS-1];

    // One quotient bit per stage, most significant first
    for (genvar i = 0; i < NS; i++)
    begin : g_stage
        localparam int K = NS - 1 - i;
        logic [DW-1:0]          rem_in [0:2];
        logic [COORD_WIDTH-1:0] q_in   [0:2];
        logic [AW-1:0]          den_in;
        logic [SIDE_W-1:0]      side_in;
        ctl_t                   ctl_in;
        logic [DW:0]            diff   [0:2];
        logic [COORD_WIDTH-1:0] q_next [0:2];

        if (i == 0)
        begin : g_first
            always_comb
            begin
                for (int l = 0; l < 3; l++)
                begin
                    rem_in[l] = in_num[l];
                    q_in[l]   = '0;
                end
                den_in  = in_den;
                side_in = in_side;
                ctl_in  = in_ctl;
            end
        end
        else
        begin : g_next
            always_comb
            begin
                for (int l = 0; l < 3; l++)
                begin
                    rem_in[l] = rem_reg[i-1][l];
                    q_in[l]   = q_reg[i-1][l];
                end
                den_in  = den_reg[i-1];
                side_in = side_reg[i-1];
                ctl_in  = ctl_reg[i-1];
            end
        end

        // Trial subtract of the shifted divisor, set this stage's quotient bit
        always_comb
        begin
            for (int l = 0; l < 3; l++)
            begin
                diff[l]   = {1'b0, rem_in[l]} - ({1'b0, DW'(den_in)} << K);
                q_next[l] = q_in[l] | (COORD_WIDTH'(!diff[l][DW]) << K);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[i] <= '0;
            end
            else if (adv)
            begin
                ctl_reg[i] <= ctl_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                den_reg[i]  <= den_in;
                side_reg[i] <= side_in;
                for (int l = 0; l < 3; l++)
                begin
                    rem_reg[i][l] <= diff[l][DW] ? rem_in[l] : diff[l][DW-1:0];
                    q_reg[i][l]   <= q_next[l];
                end
            end
        end
    end

    assign out_ctl  = ctl_reg[NS-1];
    assign out_q    = q_reg[NS-1];
    assign out_side = side_reg[NS-1];

endmodule

### design/matrix_point_transform.sv
// An input beat passes three multiply-accumulate stages, one rounding stage, one
// restoring-divider stage per quotient bit and one output stage to its result beat.
// Throughput: one beat per cycle; the whole pipeline holds while the output stalls.
// Reset (rst_n, asynchronous, active low) empties the pipeline and loads the
// identity matrix into the four row registers.
module matrix_point_transform
    import mpt_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int COEF_WIDTH  = COEF_WIDTH_DEF
)
(
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     s_tvalid,
    output logic                                     s_tready,
    // point_x, point_y, point_z
    input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]       s_tdata,
    // op
    input  logic [OP_W-1:0]                          s_tuser,
    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    // out_x, out_y, out_z
    output logic [((3*COORD_WIDTH+7)/8)*8-1:0]       m_tdata,
    // saturated, divide_by_zero
    output logic [1:0]                               m_tuser,
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]                     cfg_index,
    input  logic [ROW_W-1:0]                         cfg_data
);

    localparam int CW  = COORD_WIDTH;
    localparam int AW  = acc_width(COORD_WIDTH, COEF_WIDTH);
    localparam int DW  = div_width(COORD_WIDTH, COEF_WIDTH);
    localparam int TDW = ((3*COORD_WIDTH+7)/8)*8;
    localparam int SW  = 3 * CW + 9;
    localparam int SATF_B = 3 * CW;
    localparam int PROJ_B = 3 * CW + 1;
    localparam int DZ_B   = 3 * CW + 2;
    localparam int NEG_B  = 3 * CW + 3;
    localparam int OVF_B  = 3 * CW + 6;
    localparam logic signed [AW-1:0] SAT_HI = {{(AW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [AW-1:0] SAT_LO = ~SAT_HI;
    localparam logic [CW-1:0] OUT_HI = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] OUT_LO = {1'b1, {(CW-1){1'b0}}};

    logic [ROW_W-1:0]        rows_reg [0:NUM_ROWS-1];
    logic                    adv;
    ctl_t                    in_ctl;
    logic signed [CW-1:0]    in_p [0:2];

    ctl_t                    mac_ctl;
    logic signed [AW-1:0]    mac_acc [0:2];
    logic signed [AW-1:0]    mac_w;

    logic signed [AW-1:0]    rsh [0:2];
    logic [AW-1:0]           un [0:2];
    logic [AW-1:0]           ud;
    logic [DW-1:0]           num_next [0:2];
    logic [SW-1:0]           side_next;
    logic [CW-1:0]           res_next [0:2];
    logic [2:0]              lane_sat;
    logic [2:0]              neg_next;
    logic [2:0]              ovf_next;

    logic [DW-1:0]           num_reg [0:2];
    logic [AW-1:0]           den_reg;
    logic [SW-1:0]           side_reg;
    ctl_t                    ctl4_reg;

    ctl_t                    div_ctl;
    logic [CW-1:0]           div_q [0:2];
    logic [SW-1:0]           div_side;

    logic [CW-1:0]           fin [0:2];
    logic [2:0]              fin_sat;
    logic                    fin_dz;

    logic                    out_valid_reg;
    logic [3*CW-1:0]         out_data_reg;
    logic [1:0]              out_user_reg;

    // Whole pipeline moves while the output register can take a beat
    assign adv       = !out_valid_reg || m_tready;
    assign s_tready  = adv;
    assign cfg_ready = 1'b1;

    // Configuration rows; writes beyond the last row are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < NUM_ROWS; r++)
            begin
                rows_reg[r] <= row_reset(r);
            end
        end
        else if (cfg_valid && (cfg_index < CFG_IDX_W'(NUM_ROWS)))
        begin
            rows_reg[cfg_index[ROW_IDX_W-1:0]] <= cfg_data;
        end
    end

    always_comb
    begin
        in_ctl.valid = s_tvalid;
        in_ctl.op    = op_t'(s_tuser);
        for (int c = 0; c < 3; c++)
        begin
            in_p[c] = s_tdata[c*CW +: CW];
        end
    end

    mpt_mac #(
        .COORD_WIDTH (COORD_WIDTH),
        .COEF_WIDTH  (COEF_WIDTH)
    ) u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .in_ctl  (in_ctl),
        .in_p    (in_p),
        .rows    (rows_reg),
        .out_ctl (mac_ctl),
        .out_acc (mac_acc),
        .out_w   (mac_w)
    );

    // Round and clamp the affine modes, prepare magnitudes for the divider
    always_comb
    begin
        ud = mac_w[AW-1] ? AW'(-mac_w) : AW'(mac_w);
        for (int r = 0; r < 3; r++)
        begin
            rsh[r] = (mac_acc[r] + AW'(1 << (COEF_FRAC - 1))) >>> COEF_FRAC;
            lane_sat[r] = 1'b0;
            if (rsh[r] > SAT_HI)
            begin
                res_next[r] = OUT_HI;
                lane_sat[r] = 1'b1;
            end
            else if (rsh[r] < SAT_LO)
            begin
                res_next[r] = OUT_LO;
                lane_sat[r] = 1'b1;
            end
            else
            begin
                res_next[r] = rsh[r][CW-1:0];
            end
            un[r]       = mac_acc[r][AW-1] ? AW'(-mac_acc[r]) : AW'(mac_acc[r]);
            num_next[r] = DW'(un[r]) << COORD_FRAC;
            neg_next[r] = mac_acc[r][AW-1] ^ mac_w[AW-1];
            ovf_next[r] = num_next[r] >= (DW'(ud) << COORD_WIDTH);
        end
        side_next = '0;
        case (mac_ctl.op)
            OP_POSITION, OP_DIRECTION, OP_TRANSPOSED, OP_INV_RIGID:
            begin
                side_next[3*CW-1:0] = {res_next[2], res_next[1], res_next[0]};
                side_next[SATF_B]   = |lane_sat;
            end
            OP_PROJECTIVE:
            begin
                side_next[PROJ_B]          = 1'b1;
                side_next[DZ_B]            = (mac_w == '0);
                side_next[NEG_B +: 3]      = neg_next;
                side_next[OVF_B +: 3]      = ovf_next;
            end
            default:
            begin
                side_next[PROJ_B] = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl4_reg <= '0;
        end
        else if (adv)
        begin
            ctl4_reg <= mac_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            num_reg  <= num_next;
            den_reg  <= ud;
            side_reg <= side_next;
        end
    end

    mpt_div #(
        .COORD_WIDTH (COORD_WIDTH),
        .COEF_WIDTH  (COEF_WIDTH),
        .SIDE_W      (SW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_ctl   (ctl4_reg),
        .in_num   (num_reg),
        .in_den   (den_reg),
        .in_side  (side_reg),
        .out_ctl  (div_ctl),
        .out_q    (div_q),
        .out_side (div_side)
    );

    // Sign and clamp the quotients, or pass the rounded result
    always_comb
    begin
        fin_dz = 1'b0;
        for (int r = 0; r < 3; r++)
        begin
            fin[r]     = div_side[r*CW +: CW];
            fin_sat[r] = 1'b0;
            if (div_side[PROJ_B])
            begin
                if (div_side[DZ_B])
                begin
                    fin[r] = '0;
                    fin_dz = 1'b1;
                end
                else if (div_side[OVF_B + r])
                begin
                    fin[r]     = div_side[NEG_B + r] ? OUT_LO : OUT_HI;
                    fin_sat[r] = 1'b1;
                end
                else if (!div_side[NEG_B + r])
                begin
                    fin[r]     = div_q[r][CW-1] ? OUT_HI : div_q[r];
                    fin_sat[r] = div_q[r][CW-1];
                end
                else if (div_q[r][CW-1] && (|div_q[r][CW-2:0]))
                begin
                    fin[r]     = OUT_LO;
                    fin_sat[r] = 1'b1;
                end
                else
                begin
                    fin[r] = -div_q[r];
                end
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= div_ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= {fin[2], fin[1], fin[0]};
            out_user_reg <= {fin_dz, (|fin_sat) || div_side[SATF_B]};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDW'(out_data_reg);
    assign m_tuser  = out_user_reg;

endmodule

### design/mpt_checker.sv
module mpt_checker
    import mpt_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input logic                                     clk,
    input logic                                     rst_n,
    input logic                                     s_tready,
    input logic                                     m_tvalid,
    input logic                                     m_tready,
    input logic [((3*COORD_WIDTH+7)/8)*8-1:0]       m_tdata,
    input logic [1:0]                               m_tuser
);

    // A stalled result beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed under stall");

    // A zero divisor gives a zero point and no clamp flag
    a_dz: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> (m_tdata == '0) && !m_tuser[0])
        else $error("divide flag with non-zero result");

    // Input side stalls only behind a stalled result
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output back-pressure");

    // An empty output stage never blocks input
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled while output empty");

endmodule

bind matrix_point_transform mpt_checker #(.COORD_WIDTH(COORD_WIDTH)) u_mpt_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

### verif/matrix_point_transform_test.sv
`timescale 1ns / 1ps

module matrix_point_transform_test;
    import mpt_pkg::*;

    localparam int                 CW          = COORD_WIDTH_DEF;
    localparam int                 DW          = ((3*CW+7)/8)*8;
    localparam int                 WATCH_LIMIT = 5000;
    localparam int                 HOLD_LEN    = 400;
    localparam int                 DRAIN_WAIT  = 60;
    localparam logic [OP_W-1:0]    OP_RSVD_LO  = 3'd5;
    localparam logic [OP_W-1:0]    OP_RSVD_MID = 3'd6;
    localparam logic [OP_W-1:0]    OP_RSVD_HI  = 3'd7;
    localparam logic [CFG_IDX_W-1:0] REG_ROW0  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW1  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW2  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW3  = 8'd3;
    localparam logic [31:0]        Q_MAX       = 32'h7fff_ffff;
    localparam logic [31:0]        Q_MIN       = 32'h8000_0000;
    localparam logic [31:0]        Q_ONE       = 32'h0001_0000;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        bit          sat;
        bit          dz;
    } point_res_t;

    typedef enum bit {ROW_POINT, ROW_WRITE} row_kind_t;

    typedef struct {
        row_kind_t          kind;
        logic [OP_W-1:0]    op;
        logic [31:0]        x, y, z;
        logic [CFG_IDX_W-1:0] idx;
        logic [ROW_W-1:0]   data;
        bit                 typed;
        point_res_t         want;
    } stim_row_t;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [DW-1:0]     s_tdata;
    logic [OP_W-1:0]   s_tuser;
    logic              m_tvalid;
    logic              m_tready;
    logic [DW-1:0]     m_tdata;
    logic [1:0]        m_tuser;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [ROW_W-1:0]  cfg_data;

    logic [ROW_W-1:0]  mat_rows [NUM_ROWS];
    point_res_t        pending_pts [$];
    stim_row_t         stim_tab [$];
    int                errors;
    bit                idle_on;
    bit                hold_req;
    int                quiet_cycles;

    matrix_point_transform DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Signed Q4.12 coefficient at row r, column c
    function automatic longint coef_at(int r, int c);
        logic signed [15:0] v;
        v = mat_rows[r][COEF_STRIDE*c +: 16];
        return longint'(v);
    endfunction

    function automatic longint clamp_q16(longint v, inout bit flag);
        if (v > longint'(32'sh7fff_ffff))
        begin
            flag = 1'b1;
            return longint'(32'sh7fff_ffff);
        end
        if (v < -longint'(64'h8000_0000))
        begin
            flag = 1'b1;
            return -longint'(64'h8000_0000);
        end
        return v;
    endfunction

    // Signed quotient n * 2^16 / d, truncated toward zero
    function automatic longint proj_quotient(longint n, longint d, inout bit flag);
        bit                neg;
        longint unsigned   un, ud, q0, rem, frac, mag;
        neg  = (n < 0) != (d < 0);
        un   = (n < 0) ? -n : n;
        ud   = (d < 0) ? -d : d;
        q0   = un / ud;
        rem  = un % ud;
        frac = 0;
        if (q0 > 64'd65536)
            mag = 64'd65537 << COORD_FRAC;
        else
        begin
            for (int i = 0; i < COORD_FRAC; i++)
            begin
                rem  = rem << 1;
                frac = frac << 1;
                if (rem >= ud)
                begin
                    rem  = rem - ud;
                    frac = frac | 1;
                end
            end
            mag = (q0 << COORD_FRAC) | frac;
        end
        return clamp_q16(neg ? -longint'(mag) : longint'(mag), flag);
    endfunction

    function automatic point_res_t transform_point(logic [OP_W-1:0] op,
                                                   logic [31:0] x, logic [31:0] y,
                                                   logic [31:0] z);
        point_res_t res;
        longint     p [3];
        longint     t [3];
        longint     acc [3];
        longint     o [3];
        longint     w;
        bit         sat;
        sat = 1'b0;
        p[0] = longint'($signed(x));
        p[1] = longint'($signed(y));
        p[2] = longint'($signed(z));
        o = '{0, 0, 0};
        res.dz = 1'b0;
        if (op <= OP_PROJECTIVE)
        begin
            for (int c = 0; c < 3; c++)
                t[c] = p[c] - coef_at(c, 3) * 16;
            for (int r = 0; r < 3; r++)
            begin
                acc[r] = 0;
                for (int c = 0; c < 3; c++)
                begin
                    case (op)
                        OP_TRANSPOSED: acc[r] += coef_at(c, r) * p[c];
                        OP_INV_RIGID:  acc[r] += coef_at(c, r) * t[c];
                        default:       acc[r] += coef_at(r, c) * p[c];
                    endcase
                end
                if (op == OP_POSITION || op == OP_PROJECTIVE)
                    acc[r] += coef_at(r, 3) * 65536;
            end
            if (op == OP_PROJECTIVE)
            begin
                w = coef_at(3, 3) * 65536;
                for (int c = 0; c < 3; c++)
                    w += coef_at(3, c) * p[c];
                if (w == 0)
                    res.dz = 1'b1;
                else
                    for (int r = 0; r < 3; r++)
                        o[r] = proj_quotient(acc[r], w, sat);
            end
            else
                for (int r = 0; r < 3; r++)
                    o[r] = clamp_q16((acc[r] + 2048) >>> COEF_FRAC, sat);
        end
        res.x   = o[0][31:0];
        res.y   = o[1][31:0];
        res.z   = o[2][31:0];
        res.sat = sat;
        return res;
    endfunction

    // Coordinate mix: extremes, small values, full range
    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 7))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2:       return 32'd0;
            3, 4, 5: return 32'($urandom_range(0, 2097152)) - 32'd1048576;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [ROW_W-1:0] small_row();
        logic [ROW_W-1:0] v;
        for (int c = 0; c < 4; c++)
            v[16*c +: 16] = 16'($urandom_range(0, 16383)) - 16'd8192;
        return v;
    endfunction

    task automatic write_row(logic [CFG_IDX_W-1:0] idx, logic [ROW_W-1:0] data);
        while (pending_pts.size() != 0)
            @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        mat_rows[idx[ROW_IDX_W-1:0]] = data;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic send_point(logic [OP_W-1:0] op, logic [31:0] x, logic [31:0] y,
                              logic [31:0] z, bit typed, point_res_t want);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {z, y, x};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_pts.push_back(typed ? want : transform_point(op, x, y, z));
        @(negedge clk);
    endtask

    task automatic add_point(logic [OP_W-1:0] op, logic [31:0] x, logic [31:0] y,
                             logic [31:0] z, bit typed, logic [31:0] ex, logic [31:0] ey,
                             logic [31:0] ez, bit esat, bit edz);
        stim_row_t row;
        row.kind  = ROW_POINT;
        row.op    = op;
        row.x     = x;
        row.y     = y;
        row.z     = z;
        row.typed = typed;
        row.want  = '{ex, ey, ez, esat, edz};
        stim_tab.push_back(row);
    endtask

    task automatic add_write(logic [CFG_IDX_W-1:0] idx, logic [ROW_W-1:0] data);
        stim_row_t row;
        row.kind = ROW_WRITE;
        row.idx  = idx;
        row.data = data;
        stim_tab.push_back(row);
    endtask

    // Receiver: random stalls, plus one long hold-off on request
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            m_tready = 1'b0;
            repeat (HOLD_LEN) @(negedge clk);
            hold_req = 1'b0;
            m_tready = 1'b1;
        end
        else if (idle_on && $urandom_range(0, 4) == 0)
        begin
            m_tready = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            m_tready = 1'b1;
        end
        else
            m_tready = 1'b1;
    end

    // Compare each result beat against the oldest expectation
    always @(posedge clk)
    begin
        point_res_t exp_pt;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_pts.size() == 0)
            begin
                $error("unexpected result beat: tdata %h tuser %b", m_tdata, m_tuser);
                errors++;
            end
            else
            begin
                exp_pt = pending_pts.pop_front();
                if (m_tdata[31:0] !== exp_pt.x)
                begin
                    $error("out_x: expected %h, got %h", exp_pt.x, m_tdata[31:0]);
                    errors++;
                end
                if (m_tdata[63:32] !== exp_pt.y)
                begin
                    $error("out_y: expected %h, got %h", exp_pt.y, m_tdata[63:32]);
                    errors++;
                end
                if (m_tdata[95:64] !== exp_pt.z)
                begin
                    $error("out_z: expected %h, got %h", exp_pt.z, m_tdata[95:64]);
                    errors++;
                end
                if (m_tuser[0] !== exp_pt.sat)
                begin
                    $error("saturated: expected %b, got %b", exp_pt.sat, m_tuser[0]);
                    errors++;
                end
                if (m_tuser[1] !== exp_pt.dz)
                begin
                    $error("divide_by_zero: expected %b, got %b", exp_pt.dz, m_tuser[1]);
                    errors++;
                end
            end
        end
    end

    // Watchdog: end the run after too long without any beat
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCH_LIMIT)
        begin
            $display("matrix_point_transform_test NOT OK");
            $finish;
        end
    end

    initial
    begin
        logic [OP_W-1:0] op;
        logic [31:0]     px;
        point_res_t      none;
        errors       = 0;
        quiet_cycles = 0;
        idle_on      = 1'b1;
        hold_req     = 1'b0;
        none         = '{32'd0, 32'd0, 32'd0, 1'b0, 1'b0};
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        m_tready     = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        for (int r = 0; r < NUM_ROWS; r++)
            mat_rows[r] = ROW_W'(ONE_COEF) << (COEF_STRIDE * r);
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Identity after reset: every mode returns the point itself
        add_point(OP_POSITION, 32'd0, 32'd0, 32'd0, 1, 32'd0, 32'd0, 32'd0, 0, 0);
        add_point(OP_POSITION, Q_MAX, Q_MIN, Q_ONE, 1, Q_MAX, Q_MIN, Q_ONE, 0, 0);
        add_point(OP_DIRECTION, Q_MIN, Q_MAX, 32'hffff_ffff, 1,
                  Q_MIN, Q_MAX, 32'hffff_ffff, 0, 0);
        add_point(OP_TRANSPOSED, 32'h1234_5678, Q_MIN, Q_MAX, 1,
                  32'h1234_5678, Q_MIN, Q_MAX, 0, 0);
        add_point(OP_INV_RIGID, Q_MAX, Q_MAX, Q_MIN, 1, Q_MAX, Q_MAX, Q_MIN, 0, 0);
        add_point(OP_PROJECTIVE, Q_ONE, 32'hfffe_0000, Q_MAX, 1,
                  Q_ONE, 32'hfffe_0000, Q_MAX, 0, 0);
        // Undefined modes give all-zero results
        add_point(OP_RSVD_LO, Q_MAX, Q_ONE, Q_MIN, 1, 32'd0, 32'd0, 32'd0, 0, 0);
        add_point(OP_RSVD_MID, 32'h5555_5555, 32'haaaa_aaaa, Q_ONE, 1,
                  32'd0, 32'd0, 32'd0, 0, 0);
        add_point(OP_RSVD_HI, Q_MIN, Q_MIN, Q_MIN, 1, 32'd0, 32'd0, 32'd0, 0, 0);
        // Zero projective row: w is zero whatever the point
        add_write(REG_ROW3, 64'd0);
        add_point(OP_PROJECTIVE, Q_MAX, Q_ONE, Q_MIN, 1, 32'd0, 32'd0, 32'd0, 0, 1);
        add_point(OP_POSITION, Q_MAX, Q_ONE, Q_MIN, 0, 0, 0, 0, 0, 0);
        // Largest positive coefficients: overflow in every affine mode
        add_write(REG_ROW0, 64'h7fff_7fff_7fff_7fff);
        add_write(REG_ROW1, 64'h7fff_7fff_7fff_7fff);
        add_write(REG_ROW2, 64'h7fff_7fff_7fff_7fff);
        add_write(REG_ROW3, 64'h0000_0000_0000_0001);
        for (int k = 0; k <= OP_PROJECTIVE; k++)
            add_point(OP_W'(k), Q_MAX, Q_MAX, Q_MIN, 0, 0, 0, 0, 0, 0);
        // Most negative coefficients
        add_write(REG_ROW0, 64'h8000_8000_8000_8000);
        add_write(REG_ROW1, 64'h8000_8000_8000_8000);
        add_write(REG_ROW2, 64'h8000_8000_8000_8000);
        add_write(REG_ROW3, 64'h8000_8000_8000_8000);
        for (int k = 0; k <= OP_PROJECTIVE; k++)
            add_point(OP_W'(k), Q_MIN, Q_MIN, Q_MAX, 0, 0, 0, 0, 0, 0);

        foreach (stim_tab[i])
        begin
            if (stim_tab[i].kind == ROW_WRITE)
            begin
                s_tvalid = 1'b0;
                write_row(stim_tab[i].idx, stim_tab[i].data);
            end
            else
                send_point(stim_tab[i].op, stim_tab[i].x, stim_tab[i].y, stim_tab[i].z,
                           stim_tab[i].typed, stim_tab[i].want);
        end

        // Random phases, each under its own matrix
        for (int ph = 0; ph < 6; ph++)
        begin
            s_tvalid = 1'b0;
            idle_on  = (ph != 5);
            for (int r = 0; r < NUM_ROWS; r++)
            begin
                case (ph)
                    0:       write_row(CFG_IDX_W'(r), small_row());
                    1:       write_row(CFG_IDX_W'(r), {$urandom, $urandom});
                    2:       write_row(CFG_IDX_W'(r), small_row());
                    3:       write_row(CFG_IDX_W'(r), {$urandom, $urandom});
                    4:       write_row(CFG_IDX_W'(r), (r == 3) ? 64'h0000_0000_0000_1000
                                                               : small_row());
                    default: write_row(CFG_IDX_W'(r), ROW_W'(ONE_COEF) << (COEF_STRIDE * r));
                endcase
            end
            if (ph == 4)
                write_row(REG_ROW3, 64'h0000_0000_0000_0001);
            for (int n = 0; n < 215; n++)
            begin
                // Long output stall while inputs keep coming
                if (ph == 1 && n == 40)
                    hold_req = 1'b1;
                // Let the pipeline run dry once mid-phase
                if (ph == 2 && n == 100)
                begin
                    s_tvalid = 1'b0;
                    while (pending_pts.size() != 0)
                        @(negedge clk);
                end
                op = ($urandom_range(0, 9) == 0) ? OP_W'($urandom_range(5, 7))
                                                 : OP_W'($urandom_range(0, 4));
                px = (ph == 4 && $urandom_range(0, 2) == 0) ? 32'd0 : pick_coord();
                send_point(op, px, pick_coord(), pick_coord(), 0, none);
            end
        end
        s_tvalid = 1'b0;

        while (pending_pts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (errors == 0)
            $display("matrix_point_transform_test OK");
        else
            $display("matrix_point_transform_test NOT OK");
        $finish;
    end

endmodule
